### rtl/sbc_pkg.sv
// Package for the swept box collision core: widths, time codes, axis codes,
// and the command and status types between the controller and the datapath.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sbc_pkg;

	// Coordinate format of the input fields.
	localparam int COORD_BITS    = 32;
	localparam int FRACTION_BITS = 16;

	// Time values are signed with the same fraction bits and two guard bits.
	localparam int TIME_BITS = COORD_BITS + 2;

	// The divider produces an even number of quotient bits, two per cycle.
	localparam int DIV_BITS   = TIME_BITS + (TIME_BITS % 2);
	localparam int DIV_CYCLES = DIV_BITS / 2;
	localparam int CNT_W      = $clog2(DIV_CYCLES);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [TIME_BITS-1:0]  tval_t;
	typedef logic signed [COORD_BITS:0]   num_t;

	// The most negative code is minus infinity, the most positive plus infinity.
	localparam tval_t TIME_NEG_INF = tval_t'({1'b1, {(TIME_BITS-1){1'b0}}});
	localparam tval_t TIME_POS_INF = tval_t'({1'b0, {(TIME_BITS-1){1'b1}}});
	localparam tval_t TIME_LIMIT   = TIME_POS_INF - tval_t'(1);
	localparam tval_t TIME_ONE     = tval_t'(64'd1 << FRACTION_BITS);

	// Axis codes of the input items.
	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_Z    = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	// Divider operations issued by the controller.
	typedef enum logic [2:0] {
		DIV_HOLD,
		DIV_LOAD,
		DIV_INIT,
		DIV_STEP,
		DIV_FINISH
	} div_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		div_op_t div_op;
		logic    sel_exit;
		logic    store_entry;
		logic    update;
		logic    emit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] axis;
		logic       v_zero;
		logic       out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

### rtl/sbc_divider.sv
// Iterative signed divider that returns a saturated time code, two quotient
// bits per cycle, sequenced by the operations of the controller.
// Depends on sbc_pkg.
`default_nettype none

module sbc_divider (
	input  wire logic            clk,
	input  wire sbc_pkg::div_op_t op,
	input  wire sbc_pkg::num_t    num,
	input  wire sbc_pkg::coord_t  den,
	output sbc_pkg::tval_t        res
);
	import sbc_pkg::*;

	localparam int NUM_W = COORD_BITS + 1;
	localparam int DVD_W = NUM_W + FRACTION_BITS;
	localparam int DSH_W = COORD_BITS + DIV_BITS;
	localparam int CMP_W = (DVD_W > DSH_W) ? DVD_W : DSH_W;

	logic [NUM_W-1:0]      n_q;
	logic [COORD_BITS-1:0] d_q;
	logic                  neg_q;
	logic                  sat_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [DIV_BITS-1:0]   acc_q;
	tval_t                 res_q;

	logic [DVD_W-1:0]               dvd;
	logic                           sat_next;
	logic [COORD_BITS+DIV_BITS-1:0] step1;
	logic [COORD_BITS+DIV_BITS-1:0] step2;
	logic [DIV_BITS-1:0]            lim_ext;
	logic [DIV_BITS-1:0]            cap;
	tval_t                          mag;

	// One restoring step: shift in the next dividend bit and subtract if it fits.
	function automatic logic [COORD_BITS+DIV_BITS-1:0] div_step(
		input logic [COORD_BITS-1:0] rem,
		input logic [DIV_BITS-1:0]   acc,
		input logic [COORD_BITS-1:0] d
	);
		logic [COORD_BITS:0]   r2;
		logic [COORD_BITS:0]   diff;
		logic                  ge;
		logic [COORD_BITS-1:0] rem_n;
		r2    = {rem, acc[DIV_BITS-1]};
		diff  = r2 - {1'b0, d};
		ge    = (r2 >= {1'b0, d});
		rem_n = ge ? diff[COORD_BITS-1:0] : r2[COORD_BITS-1:0];
		return {rem_n, acc[DIV_BITS-2:0], ge};
	endfunction

	// The dividend is the numerator magnitude scaled by the fraction bits.
	assign dvd = {n_q, {FRACTION_BITS{1'b0}}};

	// A quotient that does not fit in the quotient register saturates.
	assign sat_next = (CMP_W'(dvd) >= CMP_W'({d_q, {DIV_BITS{1'b0}}}));

	// Two chained steps per cycle.
	assign step1 = div_step(rem_q, acc_q, d_q);
	assign step2 = div_step(step1[COORD_BITS+DIV_BITS-1:DIV_BITS], step1[DIV_BITS-1:0], d_q);

	// Clamp to the largest finite code, then apply the sign.
	assign lim_ext = DIV_BITS'($unsigned(TIME_LIMIT));
	assign cap     = (sat_q || (acc_q > lim_ext)) ? lim_ext : acc_q;
	assign mag     = tval_t'(cap);

	always_ff @(posedge clk) begin
		case (op)
			DIV_LOAD: begin
				n_q   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
				d_q   <= den[COORD_BITS-1] ? COORD_BITS'(-den) : COORD_BITS'(den);
				neg_q <= num[NUM_W-1] ^ den[COORD_BITS-1];
			end
			DIV_INIT: begin
				sat_q <= sat_next;
				rem_q <= COORD_BITS'(dvd >> DIV_BITS);
				acc_q <= dvd[DIV_BITS-1:0];
			end
			DIV_STEP: begin
				rem_q <= step2[COORD_BITS+DIV_BITS-1:DIV_BITS];
				acc_q <= step2[DIV_BITS-1:0];
			end
			DIV_FINISH: begin
				res_q <= neg_q ? -mag : mag;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

`default_nettype wire

### rtl/sbc_datapath.sv
// Datapath of the swept box collision core: request capture, face gaps,
// divider, sweep accumulators and the result register.
// Depends on sbc_pkg and sbc_divider.
`default_nettype none

module sbc_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sbc_pkg::dp_cmd_t   cmd,
	output sbc_pkg::dp_status_t     status,
	input  wire logic [1:0]         axis,
	input  wire sbc_pkg::coord_t    moving_lo,
	input  wire sbc_pkg::coord_t    moving_hi,
	input  wire sbc_pkg::coord_t    static_lo,
	input  wire sbc_pkg::coord_t    static_hi,
	input  wire sbc_pkg::coord_t    velocity,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic [16:0]             contact_time,
	output logic signed [1:0]       normal_x,
	output logic signed [1:0]       normal_y,
	output logic signed [1:0]       normal_z
);
	import sbc_pkg::*;

	localparam int QSHR = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
	localparam int QSHL = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;

	// Captured request.
	logic [1:0] axis_q;
	coord_t     mlo_q, mhi_q, slo_q, shi_q, vel_q;

	// Entry time of the current request, held while the exit time is divided.
	tval_t entry_t_q;

	// Sweep accumulators.
	tval_t      latest_q;
	tval_t      earliest_q;
	logic       sep_q;
	logic [1:0] entry_axis_q;
	logic       entry_up_q;

	// Result register.
	logic              out_valid_q;
	logic              hit_q;
	logic [16:0]       time_q;
	logic signed [1:0] nx_q, ny_q, nz_q;

	num_t       num_a, num_b, div_num;
	logic       v_zero, v_pos, apart;
	tval_t      div_res, entry_val, exit_val;
	logic       clr;
	tval_t      b_latest, b_earliest;
	logic       b_sep, b_up;
	logic [1:0] b_axis;
	logic       hit_c;
	tval_t      t_sel;
	logic [TIME_BITS-1:0] t_u;
	logic signed [1:0]    ncode;

	// Gaps between the faces: static_lo - moving_hi and static_hi - moving_lo.
	assign num_a  = num_t'(slo_q) - num_t'(mhi_q);
	assign num_b  = num_t'(shi_q) - num_t'(mlo_q);
	assign v_zero = (vel_q == '0);
	assign v_pos  = !vel_q[COORD_BITS-1] && !v_zero;

	// Boxes apart on this axis: moving_hi <= static_lo or moving_lo >= static_hi.
	assign apart = !num_a[COORD_BITS] || num_b[COORD_BITS] || (num_b == '0);

	// Entry uses the near gap in the direction of travel, exit the far one.
	assign div_num = (v_pos != cmd.sel_exit) ? num_a : num_b;

	sbc_divider u_div (
		.clk (clk),
		.op  (cmd.div_op),
		.num (div_num),
		.den (vel_q),
		.res (div_res)
	);

	// Zero velocity contributes infinite times.
	assign entry_val = v_zero ? TIME_NEG_INF : entry_t_q;
	assign exit_val  = v_zero ? TIME_POS_INF : div_res;

	// An x request starts a fresh sweep.
	assign clr        = (axis_q == AXIS_X);
	assign b_latest   = clr ? TIME_NEG_INF : latest_q;
	assign b_earliest = clr ? TIME_POS_INF : earliest_q;
	assign b_sep      = clr ? 1'b0 : sep_q;
	assign b_axis     = clr ? AXIS_X : entry_axis_q;
	assign b_up       = clr ? 1'b0 : entry_up_q;

	// Final decision over the accumulated sweep.
	assign hit_c = !sep_q && (latest_q <= earliest_q) && !latest_q[TIME_BITS-1]
		&& (latest_q <= TIME_ONE);
	assign t_sel = hit_c ? latest_q : TIME_ONE;
	assign t_u   = t_sel;
	assign ncode = entry_up_q ? 2'sb11 : 2'sb01;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			axis_q <= axis;
			mlo_q  <= moving_lo;
			mhi_q  <= moving_hi;
			slo_q  <= static_lo;
			shi_q  <= static_hi;
			vel_q  <= velocity;
		end
		if (cmd.store_entry) begin
			entry_t_q <= div_res;
		end
	end

	// Sweep accumulators: fold in one axis, clear when the result is emitted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q     <= TIME_NEG_INF;
			earliest_q   <= TIME_POS_INF;
			sep_q        <= 1'b0;
			entry_axis_q <= AXIS_X;
			entry_up_q   <= 1'b0;
		end else if (cmd.emit) begin
			latest_q     <= TIME_NEG_INF;
			earliest_q   <= TIME_POS_INF;
			sep_q        <= 1'b0;
			entry_axis_q <= AXIS_X;
			entry_up_q   <= 1'b0;
		end else if (cmd.update) begin
			if (entry_val > b_latest) begin
				latest_q     <= entry_val;
				entry_axis_q <= axis_q;
				entry_up_q   <= v_pos;
			end else begin
				latest_q     <= b_latest;
				entry_axis_q <= b_axis;
				entry_up_q   <= b_up;
			end
			earliest_q <= (exit_val < b_earliest) ? exit_val : b_earliest;
			sep_q      <= b_sep | (v_zero & apart);
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hit_q  <= hit_c;
			time_q <= 17'((t_u >> QSHR) << QSHL);
			nx_q   <= (hit_c && entry_axis_q == AXIS_X) ? ncode : 2'sb00;
			ny_q   <= (hit_c && entry_axis_q == AXIS_Y) ? ncode : 2'sb00;
			nz_q   <= (hit_c && entry_axis_q == AXIS_Z) ? ncode : 2'sb00;
		end
	end

	assign status.axis     = axis_q;
	assign status.v_zero   = v_zero;
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign contact_time = time_q;
	assign normal_x     = nx_q;
	assign normal_y     = ny_q;
	assign normal_z     = nz_q;

endmodule

`default_nettype wire

### rtl/sbc_ctrl.sv
// Controller of the swept box collision core: sequences capture, the two
// divisions, the accumulator update and the result hand-off.
// Depends on sbc_pkg.
`default_nettype none

module sbc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire sbc_pkg::dp_status_t status,
	output sbc_pkg::dp_cmd_t         cmd
);
	import sbc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INIT,
		ST_STEP,
		ST_FINISH,
		ST_LOAD_EXIT,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic             exit_q;
	logic [CNT_W-1:0] cnt_q;

	logic run_div;

	// A request with a real axis and a moving box needs both divisions.
	assign run_div = (status.axis != AXIS_NONE) && !status.v_zero;

	// State, division select and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			exit_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					exit_q <= 1'b0;
					if (status.axis == AXIS_NONE) begin
						state_q <= ST_IDLE;
					end else if (status.v_zero) begin
						state_q <= ST_UPDATE;
					end else begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_FINISH: begin
					state_q <= exit_q ? ST_UPDATE : ST_LOAD_EXIT;
				end
				ST_LOAD_EXIT: begin
					exit_q  <= 1'b1;
					state_q <= ST_INIT;
				end
				ST_UPDATE: begin
					state_q <= (status.axis == AXIS_Z) ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd             = '0;
		cmd.div_op      = DIV_HOLD;
		in_ready        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DISPATCH: begin
				cmd.div_op = run_div ? DIV_LOAD : DIV_HOLD;
			end
			ST_INIT: begin
				cmd.div_op = DIV_INIT;
			end
			ST_STEP: begin
				cmd.div_op = DIV_STEP;
			end
			ST_FINISH: begin
				cmd.div_op = DIV_FINISH;
			end
			ST_LOAD_EXIT: begin
				cmd.div_op      = DIV_LOAD;
				cmd.sel_exit    = 1'b1;
				cmd.store_entry = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = !status.out_busy;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/swept_box_collision_core.sv
// Swept box collision core: one moving box swept along a velocity against a
// static box, one request per axis in the order x, y, z.
//
// Input channel: in_valid / in_ready with axis, the two boxes' extents and the
// velocity on that axis, signed Q16.16. A request on axis x starts a sweep,
// axis z ends it; axis code 3 is dropped without a result.
// Output channel: out_valid / out_ready with hit, contact_time (Q1.16, 1.0 on
// a miss) and the contact normal, one result per z request.
// A request with nonzero velocity runs two divisions, entry time then exit
// time, through one shared divider that retires two quotient bits per cycle,
// then an update state; a request with zero velocity goes straight to the
// update state, and a request with axis code 3 is dropped after dispatch. A
// new request is accepted only once the core is idle again. On a z request
// out_valid rises from the output register written in the emit state.
// The result sits in an output register, so a new sweep is accepted while it
// waits; a stalled receiver only holds the core at the end of the next z
// request. Reset clears the sweep state and the output valid flag.
// Depends on sbc_pkg, sbc_ctrl, sbc_datapath and sbc_divider.
`default_nettype none

module swept_box_collision_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        axis,
	input  wire sbc_pkg::coord_t   moving_lo,
	input  wire sbc_pkg::coord_t   moving_hi,
	input  wire sbc_pkg::coord_t   static_lo,
	input  wire sbc_pkg::coord_t   static_hi,
	input  wire sbc_pkg::coord_t   velocity,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   hit,
	output logic [16:0]            contact_time,
	output logic signed [1:0]      normal_x,
	output logic signed [1:0]      normal_y,
	output logic signed [1:0]      normal_z
);
	import sbc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	sbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sbc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.axis         (axis),
		.moving_lo    (moving_lo),
		.moving_hi    (moving_hi),
		.static_lo    (static_lo),
		.static_hi    (static_hi),
		.velocity     (velocity),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.contact_time (contact_time),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z)
	);

endmodule

`default_nettype wire
